/* hdl/rcm_pkg.sv */
package rcm_pkg;

    localparam int LETTERS     = 26;
    localparam int LETTER_W    = 5;
    localparam int TYPE_W      = 3;
    localparam int ACTION_W    = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 5;
    localparam int ROTOR_TYPES = 8;

    // Letter path stages behind the middle queue: plugboard in, three forward rotors
    // (the reflector rides with the left one), three inverse rotors with plugboard out.
    localparam int PIPE_STAGES = 7;

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 16;

    localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;

    localparam logic [ACTION_W-1:0] ACT_ENCODE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PLUG   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_TYPE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIDDLE_TYPE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_TYPE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_RING  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIDDLE_RING = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_RING   = 3'd5;

    localparam logic [TYPE_W-1:0] ROTOR_I   = 3'd0;
    localparam logic [TYPE_W-1:0] ROTOR_II  = 3'd1;
    localparam logic [TYPE_W-1:0] ROTOR_III = 3'd2;
    localparam logic [TYPE_W-1:0] ROTOR_IV  = 3'd3;
    localparam logic [TYPE_W-1:0] ROTOR_V   = 3'd4;

    localparam logic [LETTER_W-1:0] KNOCK_I     = 5'd17;
    localparam logic [LETTER_W-1:0] KNOCK_II    = 5'd5;
    localparam logic [LETTER_W-1:0] KNOCK_III   = 5'd22;
    localparam logic [LETTER_W-1:0] KNOCK_IV    = 5'd10;
    localparam logic [LETTER_W-1:0] KNOCK_V     = 5'd0;
    localparam logic [LETTER_W-1:0] KNOCK_EXTRA = 5'd13;

    localparam logic [7:0] ASCII_A = 8'd65;

    // Wirings as ASCII strings, first letter in the top byte.
    localparam logic [8*LETTERS-1:0] WIRING [ROTOR_TYPES] = '{
        "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
        "AJDKSIRUXBLHWTMCQGZNPYFVOE",
        "BDFHJLCPRTXVZNYEIWGAKMUSQO",
        "ESOVPZJAYQUIRHXLNFTGKDCMWB",
        "VZBRGITYUPSDNHLXAWMJQOFECK",
        "JPGVOUMFYQBENHZRDKASXLICTW",
        "NZJHGRCXMYSWBOUFAIVLPEKQDT",
        "FKQHTLXOCBJSPDZRAMEWNIUYGV"
    };

    localparam logic [8*LETTERS-1:0] REFLECTOR_B = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

    typedef struct packed {
        logic [TYPE_W-1:0]   right_type;
        logic [TYPE_W-1:0]   middle_type;
        logic [TYPE_W-1:0]   left_type;
        logic [LETTER_W-1:0] right_ring;
        logic [LETTER_W-1:0] middle_ring;
        logic [LETTER_W-1:0] left_ring;
    } cfg_t;

    typedef struct packed {
        logic [LETTER_W-1:0] right;
        logic [LETTER_W-1:0] middle;
        logic [LETTER_W-1:0] left;
    } pos_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                plug_write;
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] plug_value;
        pos_t                pos;
    } item_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        pos_t                pos;
        logic [LETTER_W-1:0] n;
    } stage_t;

    typedef struct packed {
        logic [LETTER_W-1:0] cipher;
        pos_t                pos;
    } result_t;

    function automatic logic [LETTER_W-1:0] fold26(input logic [LETTER_W-1:0] x);
        return (x >= LETTER_W'(LETTERS)) ? LETTER_W'(x - LETTER_W'(LETTERS)) : x;
    endfunction

    function automatic logic [LETTER_W-1:0] inc26(input logic [LETTER_W-1:0] x);
        return (x >= LAST_LETTER) ? '0 : LETTER_W'(x + 1'b1);
    endfunction

    function automatic logic [LETTER_W-1:0] add26(input logic [LETTER_W-1:0] a,
                                                  input logic [LETTER_W-1:0] b);
        logic [LETTER_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (LETTER_W+1)'(LETTERS))
            s = s - (LETTER_W+1)'(LETTERS);
        return s[LETTER_W-1:0];
    endfunction

    function automatic logic [LETTER_W-1:0] sub26(input logic [LETTER_W-1:0] a,
                                                  input logic [LETTER_W-1:0] b);
        logic [LETTER_W:0] s;
        s = {1'b0, a} - {1'b0, b};
        if (a < b)
            s = s + (LETTER_W+1)'(LETTERS);
        return s[LETTER_W-1:0];
    endfunction

    function automatic logic [LETTER_W-1:0] wire_fwd(input logic [TYPE_W-1:0] kind,
                                                     input logic [LETTER_W-1:0] x);
        logic [8*LETTERS-1:0] w;
        logic [7:0]           ch;
        w  = WIRING[kind];
        ch = w[8*(LETTERS-1-int'(x)) +: 8];
        return LETTER_W'(ch - ASCII_A);
    endfunction

    // Inverse wiring: 26 parallel compares against the forward table.
    function automatic logic [LETTER_W-1:0] wire_inv(input logic [TYPE_W-1:0] kind,
                                                     input logic [LETTER_W-1:0] x);
        logic [LETTER_W-1:0] r;
        r = '0;
        for (int i = 0; i < LETTERS; i++) begin
            if (wire_fwd(kind, LETTER_W'(i)) == x)
                r = LETTER_W'(i);
        end
        return r;
    endfunction

    function automatic logic [LETTER_W-1:0] reflect(input logic [LETTER_W-1:0] x);
        logic [7:0] ch;
        ch = REFLECTOR_B[8*(LETTERS-1-int'(x)) +: 8];
        return LETTER_W'(ch - ASCII_A);
    endfunction

    function automatic logic [LETTER_W-1:0] rotor_pass(input logic [LETTER_W-1:0] x,
                                                       input logic [LETTER_W-1:0] ring,
                                                       input logic [LETTER_W-1:0] pos,
                                                       input logic [TYPE_W-1:0]   kind,
                                                       input logic                inverse);
        logic [LETTER_W-1:0] c;
        c = sub26(add26(x, pos), ring);
        c = inverse ? wire_inv(kind, c) : wire_fwd(kind, c);
        return add26(sub26(c, pos), ring);
    endfunction

    function automatic logic knock_hit(input logic [TYPE_W-1:0]   kind,
                                       input logic [LETTER_W-1:0] pos);
        logic hit;
        case (kind)
            ROTOR_I:   hit = (pos == KNOCK_I);
            ROTOR_II:  hit = (pos == KNOCK_II);
            ROTOR_III: hit = (pos == KNOCK_III);
            ROTOR_IV:  hit = (pos == KNOCK_IV);
            ROTOR_V:   hit = (pos == KNOCK_V);
            default:   hit = (pos == KNOCK_V) || (pos == KNOCK_EXTRA);
        endcase
        return hit;
    endfunction

endpackage

/* hdl/rcm_ram.sv */
module rcm_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr_a,
    output logic [Width-1:0]         rdata_a,
    input  logic [$clog2(Depth)-1:0] raddr_b,
    output logic [Width-1:0]         rdata_b
);

    logic [Width-1:0] mem_reg [Depth];

    // Reads return the contents from before a write at the same edge.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

/* hdl/rcm_fifo.sv */
module rcm_fifo #(
    parameter int Width = 8,
    parameter int Depth = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [Width-1:0]           push_data,
    output logic                       full,
    input  logic                       pop,
    output logic [Width-1:0]           pop_data,
    output logic                       empty,
    output logic [$clog2(Depth+1)-1:0] count
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth+1);

    logic [Width-1:0] mem_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CntW'(Depth));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth-1)) ? '0 : PtrW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth-1)) ? '0 : PtrW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CntW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CntW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/rcm_front.sv */
module rcm_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rcm_pkg::cfg_t                        cfg,
    input  logic                                 accept,
    input  logic [rcm_pkg::ACTION_W-1:0]         action,
    input  logic [rcm_pkg::LETTER_W-1:0]         letter,
    input  logic [rcm_pkg::LETTER_W-1:0]         plug_value,
    input  logic [rcm_pkg::LETTER_W-1:0]         load_right_position,
    input  logic [rcm_pkg::LETTER_W-1:0]         load_middle_position,
    input  logic [rcm_pkg::LETTER_W-1:0]         load_left_position,
    output rcm_pkg::item_t                       item
);

    logic [rcm_pkg::LETTER_W-1:0] right_pos_reg, right_pos_next;
    logic [rcm_pkg::LETTER_W-1:0] middle_pos_reg, middle_pos_next;
    logic [rcm_pkg::LETTER_W-1:0] left_pos_reg, left_pos_next;
    logic                         right_seen_reg, right_seen_next;
    logic                         middle_seen_reg, middle_seen_next;
    logic [rcm_pkg::LETTER_W-1:0] right_stepped;
    logic                         right_knock;
    logic                         middle_knock;

    // The right knock looks at the stepped position, the middle one at the
    // position before this item.
    assign right_stepped = rcm_pkg::inc26(right_pos_reg);
    assign right_knock   = rcm_pkg::knock_hit(cfg.right_type, right_stepped);
    assign middle_knock  = rcm_pkg::knock_hit(cfg.middle_type, middle_pos_reg);

    always_comb
    begin
        right_pos_next   = right_pos_reg;
        middle_pos_next  = middle_pos_reg;
        left_pos_next    = left_pos_reg;
        right_seen_next  = right_seen_reg;
        middle_seen_next = middle_seen_reg;
        case (action)
            rcm_pkg::ACT_ENCODE:
            begin
                right_pos_next = right_stepped;
                if (!right_seen_reg && right_knock)
                begin
                    middle_pos_next = rcm_pkg::inc26(middle_pos_reg);
                end
                if (!middle_seen_reg && middle_knock)
                begin
                    left_pos_next = rcm_pkg::inc26(left_pos_reg);
                end
                right_seen_next  = right_knock;
                middle_seen_next = middle_knock;
            end
            rcm_pkg::ACT_LOAD:
            begin
                right_pos_next   = rcm_pkg::fold26(load_right_position);
                middle_pos_next  = rcm_pkg::fold26(load_middle_position);
                left_pos_next    = rcm_pkg::fold26(load_left_position);
                right_seen_next  = 1'b0;
                middle_seen_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        item.action     = action;
        item.plug_write = (action == rcm_pkg::ACT_PLUG) &&
                          (letter < rcm_pkg::LETTER_W'(rcm_pkg::LETTERS));
        item.letter     = rcm_pkg::fold26(letter);
        item.plug_value = rcm_pkg::fold26(plug_value);
        item.pos.right  = right_pos_next;
        item.pos.middle = middle_pos_next;
        item.pos.left   = left_pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_pos_reg   <= '0;
            middle_pos_reg  <= '0;
            left_pos_reg    <= '0;
            right_seen_reg  <= 1'b0;
            middle_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            right_pos_reg   <= right_pos_next;
            middle_pos_reg  <= middle_pos_next;
            left_pos_reg    <= left_pos_next;
            right_seen_reg  <= right_seen_next;
            middle_seen_reg <= middle_seen_next;
        end
    end

endmodule

/* hdl/rcm_back.sv */
module rcm_back #(
    parameter int OutDepth = rcm_pkg::OUT_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcm_pkg::cfg_t                 cfg,
    input  logic                          head_valid,
    input  rcm_pkg::item_t                head,
    output logic                          head_pop,
    input  logic [$clog2(OutDepth+1)-1:0] out_count,
    output logic                          res_push,
    output rcm_pkg::result_t              res
);

    localparam int LW   = rcm_pkg::LETTER_W;
    localparam int NS   = rcm_pkg::PIPE_STAGES;
    localparam int SumW = $clog2(OutDepth + NS + 2);

    rcm_pkg::stage_t   pipe_reg [NS];
    rcm_pkg::stage_t   pipe_next [NS];
    logic [NS-1:0]     vld_reg, vld_next;
    logic [rcm_pkg::LETTERS-1:0] plug_valid_reg;

    logic              valid_a_reg, valid_b_reg;
    logic [LW-1:0]     addr_a_reg, addr_b_reg;
    logic [LW-1:0]     ram_a, ram_b;
    logic [LW-1:0]     plug_in, plug_out;
    logic              ram_we;
    logic              hazard;
    logic [SumW-1:0]   used;
    logic              credit_ok;

    // An encode still short of its outgoing plugboard read would see a later
    // plugboard write, so such a write waits at the head of the queue.
    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < NS - 2; k++)
        begin
            if (vld_reg[k] && (pipe_reg[k].action == rcm_pkg::ACT_ENCODE))
                hazard = 1'b1;
        end
    end

    // Every item in the pipeline holds a reserved slot in the result queue.
    assign used      = SumW'(out_count) + SumW'($countones(vld_reg));
    assign credit_ok = (used < SumW'(OutDepth));
    assign head_pop  = head_valid && credit_ok && !(head.plug_write && hazard);
    assign ram_we    = head_pop && head.plug_write;

    rcm_ram #(
        .Width (LW),
        .Depth (rcm_pkg::LETTERS)
    ) u_plug_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (head.letter),
        .wdata   (head.plug_value),
        .raddr_a (head.letter),
        .rdata_a (ram_a),
        .raddr_b (pipe_next[NS-1].n),
        .rdata_b (ram_b)
    );

    // Entries never written read as themselves.
    assign plug_in  = valid_a_reg ? ram_a : addr_a_reg;
    assign plug_out = valid_b_reg ? ram_b : addr_b_reg;

    always_comb
    begin
        pipe_next[0].action = head.action;
        pipe_next[0].pos    = head.pos;
        pipe_next[0].n      = head.letter;
        for (int k = 1; k < NS; k++)
        begin
            pipe_next[k] = pipe_reg[k-1];
        end
        pipe_next[1].n = rcm_pkg::rotor_pass(plug_in, cfg.right_ring,
                                             pipe_reg[0].pos.right, cfg.right_type, 1'b0);
        pipe_next[2].n = rcm_pkg::rotor_pass(pipe_reg[1].n, cfg.middle_ring,
                                             pipe_reg[1].pos.middle, cfg.middle_type, 1'b0);
        pipe_next[3].n = rcm_pkg::reflect(
                             rcm_pkg::rotor_pass(pipe_reg[2].n, cfg.left_ring,
                                                 pipe_reg[2].pos.left, cfg.left_type, 1'b0));
        pipe_next[4].n = rcm_pkg::rotor_pass(pipe_reg[3].n, cfg.left_ring,
                                             pipe_reg[3].pos.left, cfg.left_type, 1'b1);
        pipe_next[5].n = rcm_pkg::rotor_pass(pipe_reg[4].n, cfg.middle_ring,
                                             pipe_reg[4].pos.middle, cfg.middle_type, 1'b1);
        pipe_next[6].n = rcm_pkg::rotor_pass(pipe_reg[5].n, cfg.right_ring,
                                             pipe_reg[5].pos.right, cfg.right_type, 1'b1);
        vld_next = {vld_reg[NS-2:0], head_pop};
    end

    assign res_push   = vld_reg[NS-1];
    assign res.pos    = pipe_reg[NS-1].pos;
    assign res.cipher = (pipe_reg[NS-1].action == rcm_pkg::ACT_ENCODE) ? plug_out : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            plug_valid_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (ram_we)
            begin
                plug_valid_reg[head.letter] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            pipe_reg[k] <= pipe_next[k];
        end
        valid_a_reg <= plug_valid_reg[head.letter];
        addr_a_reg  <= head.letter;
        valid_b_reg <= plug_valid_reg[pipe_next[NS-1].n];
        addr_b_reg  <= pipe_next[NS-1].n;
    end

endmodule

/* hdl/rotor_cipher_machine_unit.sv */
// Channel   Handshake                   Payload
// -------   -------------------------   ---------------------------------------------
// input     push / full                 action, letter, plug_value, load_*_position
// result    empty / pop                 cipher_letter, right/middle/left_position_now
// config    cfg_valid / cfg_ready       cfg_index, cfg_data
//
// One item per cycle sustained for encodes and loads while results are popped. An item
// is taken into the middle queue and then passes the letter pipeline stages before its
// result is written to the result queue, whose head drives the result ports. A plugboard
// write waits at the queue head while an encode is still short of its outgoing plugboard
// read.
// Reset clears rotor state, queues and the plugboard valid bits; no clearing pass.
// full rises only when the middle queue fills, which happens once the result queue
// has no room for what the pipeline holds or while plugboard writes wait on encodes.
module rotor_cipher_machine_unit #(
    parameter int MidDepth = rcm_pkg::MID_DEPTH_DEF,
    parameter int OutDepth = rcm_pkg::OUT_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [rcm_pkg::ACTION_W-1:0]        action,
    input  logic [rcm_pkg::LETTER_W-1:0]        letter,
    input  logic [rcm_pkg::LETTER_W-1:0]        plug_value,
    input  logic [rcm_pkg::LETTER_W-1:0]        load_right_position,
    input  logic [rcm_pkg::LETTER_W-1:0]        load_middle_position,
    input  logic [rcm_pkg::LETTER_W-1:0]        load_left_position,
    output logic                                empty,
    input  logic                                pop,
    output logic [rcm_pkg::LETTER_W-1:0]        cipher_letter,
    output logic [rcm_pkg::LETTER_W-1:0]        right_position_now,
    output logic [rcm_pkg::LETTER_W-1:0]        middle_position_now,
    output logic [rcm_pkg::LETTER_W-1:0]        left_position_now,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rcm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    rcm_pkg::cfg_t    cfg_reg, cfg_next;
    rcm_pkg::item_t   front_item;
    rcm_pkg::item_t   head_item;
    rcm_pkg::result_t res_item;
    rcm_pkg::result_t out_item;
    logic             in_accept;
    logic             mid_empty;
    logic             mid_pop;
    logic             res_push;
    logic             out_full;
    logic [$clog2(OutDepth+1)-1:0] out_count;

    assign cfg_ready = 1'b1;
    assign in_accept = push && !full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                rcm_pkg::CFG_RIGHT_TYPE:  cfg_next.right_type  = cfg_data[rcm_pkg::TYPE_W-1:0];
                rcm_pkg::CFG_MIDDLE_TYPE: cfg_next.middle_type = cfg_data[rcm_pkg::TYPE_W-1:0];
                rcm_pkg::CFG_LEFT_TYPE:   cfg_next.left_type   = cfg_data[rcm_pkg::TYPE_W-1:0];
                rcm_pkg::CFG_RIGHT_RING:  cfg_next.right_ring  = rcm_pkg::fold26(cfg_data);
                rcm_pkg::CFG_MIDDLE_RING: cfg_next.middle_ring = rcm_pkg::fold26(cfg_data);
                rcm_pkg::CFG_LEFT_RING:   cfg_next.left_ring   = rcm_pkg::fold26(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.right_type  <= rcm_pkg::ROTOR_III;
            cfg_reg.middle_type <= rcm_pkg::ROTOR_II;
            cfg_reg.left_type   <= rcm_pkg::ROTOR_I;
            cfg_reg.right_ring  <= '0;
            cfg_reg.middle_ring <= '0;
            cfg_reg.left_ring   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rcm_front u_front (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg_reg),
        .accept               (in_accept),
        .action               (action),
        .letter               (letter),
        .plug_value           (plug_value),
        .load_right_position  (load_right_position),
        .load_middle_position (load_middle_position),
        .load_left_position   (load_left_position),
        .item                 (front_item)
    );

    rcm_fifo #(
        .Width ($bits(rcm_pkg::item_t)),
        .Depth (MidDepth)
    ) u_mid_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_item),
        .full      (full),
        .pop       (mid_pop),
        .pop_data  (head_item),
        .empty     (mid_empty),
        .count     ()
    );

    rcm_back #(
        .OutDepth (OutDepth)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (!mid_empty),
        .head       (head_item),
        .head_pop   (mid_pop),
        .out_count  (out_count),
        .res_push   (res_push),
        .res        (res_item)
    );

    rcm_fifo #(
        .Width ($bits(rcm_pkg::result_t)),
        .Depth (OutDepth)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_item),
        .full      (out_full),
        .pop       (pop),
        .pop_data  (out_item),
        .empty     (empty),
        .count     (out_count)
    );

    assign cipher_letter       = out_item.cipher;
    assign right_position_now  = out_item.pos.right;
    assign middle_position_now = out_item.pos.middle;
    assign left_position_now   = out_item.pos.left;

`ifndef SYNTH
    // The reservation scheme must never let a finished item meet a full result queue.
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !out_full)
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n) mid_pop |-> !mid_empty)
        else $error("back end took an item from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (cipher_letter < rcm_pkg::LETTER_W'(rcm_pkg::LETTERS)) &&
                   (right_position_now < rcm_pkg::LETTER_W'(rcm_pkg::LETTERS)) &&
                   (middle_position_now < rcm_pkg::LETTER_W'(rcm_pkg::LETTERS)) &&
                   (left_position_now < rcm_pkg::LETTER_W'(rcm_pkg::LETTERS)))
        else $error("result letter out of range");
`endif

endmodule

/* tb/rotor_cipher_machine_unit_tb.sv */
module rotor_cipher_machine_unit_tb;

    import rcm_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 85;
    localparam int SETTLE      = 16;
    localparam int QUIET_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;

    // Keeps its own copy of the machine: settings, rotor positions, knock edge
    // flags and plugboard, and queues one expected result per accepted item.
    class cipher_scoreboard;
        string               rotor_wiring [ROTOR_TYPES];
        string               reflector;
        logic [LETTER_W-1:0] knock_a [ROTOR_TYPES];
        logic [LETTER_W-1:0] knock_b [ROTOR_TYPES];

        logic [TYPE_W-1:0]   right_type, middle_type, left_type;
        logic [LETTER_W-1:0] right_ring, middle_ring, left_ring;
        logic [LETTER_W-1:0] right_pos, middle_pos, left_pos;
        bit                  right_seen, middle_seen;
        logic [LETTER_W-1:0] plugs [LETTERS];

        result_t             cipher_due_q [$];
        int                  mismatches, results_checked;
        int                  encodes, loads, plug_writes, others;

        function new();
            rotor_wiring[0] = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
            rotor_wiring[1] = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
            rotor_wiring[2] = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
            rotor_wiring[3] = "ESOVPZJAYQUIRHXLNFTGKDCMWB";
            rotor_wiring[4] = "VZBRGITYUPSDNHLXAWMJQOFECK";
            rotor_wiring[5] = "JPGVOUMFYQBENHZRDKASXLICTW";
            rotor_wiring[6] = "NZJHGRCXMYSWBOUFAIVLPEKQDT";
            rotor_wiring[7] = "FKQHTLXOCBJSPDZRAMEWNIUYGV";
            reflector       = "YRUHQSLDPXNGOKMIEBFZCWVJAT";
            knock_a = '{KNOCK_I, KNOCK_II, KNOCK_III, KNOCK_IV, KNOCK_V,
                        KNOCK_V, KNOCK_V, KNOCK_V};
            knock_b = '{KNOCK_I, KNOCK_II, KNOCK_III, KNOCK_IV, KNOCK_V,
                        KNOCK_EXTRA, KNOCK_EXTRA, KNOCK_EXTRA};
            right_type  = ROTOR_III;
            middle_type = ROTOR_II;
            left_type   = ROTOR_I;
            right_ring  = '0;
            middle_ring = '0;
            left_ring   = '0;
            right_pos   = '0;
            middle_pos  = '0;
            left_pos    = '0;
            right_seen  = 1'b0;
            middle_seen = 1'b0;
            for (int i = 0; i < LETTERS; i++)
                plugs[i] = LETTER_W'(i);
        endfunction

        function int wrap(int x);
            return (x >= LETTERS) ? x - LETTERS : x;
        endfunction

        function logic [LETTER_W-1:0] next_pos(logic [LETTER_W-1:0] p);
            return (p >= LAST_LETTER) ? '0 : LETTER_W'(p + 1);
        endfunction

        function bit on_knock(logic [TYPE_W-1:0] kind, logic [LETTER_W-1:0] p);
            return (p == knock_a[kind]) || (p == knock_b[kind]);
        endfunction

        function int letter_of(byte ch);
            return int'(ch) - int'(ASCII_A);
        endfunction

        // One rotor stage: shift into the rotor frame, through the wiring in the
        // given direction, and back out.
        function int through_rotor(int x, int ring, int p, logic [TYPE_W-1:0] kind,
                                   bit backward);
            int c;
            int mapped;
            c = (x + LETTERS - ring + p) % LETTERS;
            mapped = 0;
            if (!backward)
                mapped = letter_of(rotor_wiring[kind][c]);
            else
                for (int i = 0; i < LETTERS; i++)
                    if (letter_of(rotor_wiring[kind][i]) == c)
                        mapped = i;
            return (mapped + LETTERS - p + ring) % LETTERS;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_RIGHT_TYPE:  right_type  = TYPE_W'(val);
                CFG_MIDDLE_TYPE: middle_type = TYPE_W'(val);
                CFG_LEFT_TYPE:   left_type   = TYPE_W'(val);
                CFG_RIGHT_RING:  right_ring  = val;
                CFG_MIDDLE_RING: middle_ring = val;
                CFG_LEFT_RING:   left_ring   = val;
                default: ;
            endcase
        endfunction

        // The middle knock looks at the middle position before it steps; the
        // right knock at the right position after it steps.
        function void advance_rotors();
            bit k_right;
            bit k_middle;
            right_pos = next_pos(right_pos);
            k_right  = on_knock(right_type, right_pos);
            k_middle = on_knock(middle_type, middle_pos);
            if (!right_seen && k_right)
                middle_pos = next_pos(middle_pos);
            if (!middle_seen && k_middle)
                left_pos = next_pos(left_pos);
            right_seen  = k_right;
            middle_seen = k_middle;
        endfunction

        function void note_input(logic [ACTION_W-1:0] act, logic [LETTER_W-1:0] ltr,
                                 logic [LETTER_W-1:0] pv, logic [LETTER_W-1:0] lr,
                                 logic [LETTER_W-1:0] lm, logic [LETTER_W-1:0] ll);
            result_t due;
            int      n, r1, r2, r3;
            due = '0;
            case (act)
                ACT_ENCODE:
                begin
                    r1 = wrap(right_ring);
                    r2 = wrap(middle_ring);
                    r3 = wrap(left_ring);
                    advance_rotors();
                    n = plugs[wrap(ltr)];
                    n = through_rotor(n, r1, right_pos, right_type, 1'b0);
                    n = through_rotor(n, r2, middle_pos, middle_type, 1'b0);
                    n = through_rotor(n, r3, left_pos, left_type, 1'b0);
                    n = letter_of(reflector[n]);
                    n = through_rotor(n, r3, left_pos, left_type, 1'b1);
                    n = through_rotor(n, r2, middle_pos, middle_type, 1'b1);
                    n = through_rotor(n, r1, right_pos, right_type, 1'b1);
                    due.cipher = plugs[n];
                    encodes++;
                end
                ACT_LOAD:
                begin
                    right_pos   = LETTER_W'(wrap(lr));
                    middle_pos  = LETTER_W'(wrap(lm));
                    left_pos    = LETTER_W'(wrap(ll));
                    right_seen  = 1'b0;
                    middle_seen = 1'b0;
                    loads++;
                end
                ACT_PLUG:
                begin
                    if (ltr < LETTERS)
                        plugs[ltr] = LETTER_W'(wrap(pv));
                    plug_writes++;
                end
                default: others++;
            endcase
            due.pos.right  = right_pos;
            due.pos.middle = middle_pos;
            due.pos.left   = left_pos;
            cipher_due_q.push_back(due);
        endfunction

        function void check_result(logic [LETTER_W-1:0] c, logic [LETTER_W-1:0] r,
                                   logic [LETTER_W-1:0] m, logic [LETTER_W-1:0] l);
            result_t due;
            bit      bad;
            results_checked++;
            if (cipher_due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: result %0d/%0d/%0d/%0d with nothing outstanding",
                             c, r, m, l);
                return;
            end
            due = cipher_due_q.pop_front();
            bad = (c !== due.cipher) || (r !== due.pos.right) ||
                  (m !== due.pos.middle) || (l !== due.pos.left);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("ERROR: result %0d: cipher %0d/%0d right %0d/%0d (expected/actual)",
                             results_checked, due.cipher, c, due.pos.right, r);
                    $display("       middle %0d/%0d left %0d/%0d (expected/actual)",
                             due.pos.middle, m, due.pos.left, l);
                end
            end
        endfunction

        function int pending();
            return cipher_due_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [ACTION_W-1:0]    action;
    logic [LETTER_W-1:0]    letter;
    logic [LETTER_W-1:0]    plug_value;
    logic [LETTER_W-1:0]    load_right_position;
    logic [LETTER_W-1:0]    load_middle_position;
    logic [LETTER_W-1:0]    load_left_position;
    logic                   empty;
    logic                   pop;
    logic [LETTER_W-1:0]    cipher_letter;
    logic [LETTER_W-1:0]    right_position_now;
    logic [LETTER_W-1:0]    middle_position_now;
    logic [LETTER_W-1:0]    left_position_now;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cipher_scoreboard sb;
    int send_gap_pct;
    int pop_stall_pct;
    int quiet_cycles;
    int settings_used;

    rotor_cipher_machine_unit dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .full                (full),
        .action              (action),
        .letter              (letter),
        .plug_value          (plug_value),
        .load_right_position (load_right_position),
        .load_middle_position(load_middle_position),
        .load_left_position  (load_left_position),
        .empty               (empty),
        .pop                 (pop),
        .cipher_letter       (cipher_letter),
        .right_position_now  (right_position_now),
        .middle_position_now (middle_position_now),
        .left_position_now   (left_position_now),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop = rst_n && ($urandom_range(0, 99) >= pop_stall_pct);
        end
    end

    // Every handshake is observed here, at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_input(action, letter, plug_value, load_right_position,
                              load_middle_position, load_left_position);
            if (pop && !empty)
                sb.check_result(cipher_letter, right_position_now,
                                middle_position_now, left_position_now);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("rotor_cipher_machine_unit verification failed");
                $finish;
            end
        end
    end

    task automatic drive_item(input logic [ACTION_W-1:0] act, input logic [LETTER_W-1:0] ltr,
                              input logic [LETTER_W-1:0] pv, input logic [LETTER_W-1:0] lr,
                              input logic [LETTER_W-1:0] lm, input logic [LETTER_W-1:0] ll);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push                 = 1'b1;
        action               = act;
        letter               = ltr;
        plug_value           = pv;
        load_right_position  = lr;
        load_middle_position = lm;
        load_left_position   = ll;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_results();
        push = 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic apply_setting(input logic [TYPE_W-1:0] rt, input logic [TYPE_W-1:0] mt,
                                 input logic [TYPE_W-1:0] lt, input logic [LETTER_W-1:0] rr,
                                 input logic [LETTER_W-1:0] mr, input logic [LETTER_W-1:0] lr);
        write_reg(CFG_RIGHT_TYPE, CFG_DATA_W'(rt));
        write_reg(CFG_MIDDLE_TYPE, CFG_DATA_W'(mt));
        write_reg(CFG_LEFT_TYPE, CFG_DATA_W'(lt));
        write_reg(CFG_RIGHT_RING, rr);
        write_reg(CFG_MIDDLE_RING, mr);
        write_reg(CFG_LEFT_RING, lr);
        settings_used++;
    endtask

    function automatic logic [LETTER_W-1:0] any_letter();
        if ($urandom_range(0, 9) == 0)
            return LETTER_W'($urandom_range(LETTERS, 31));
        return LETTER_W'($urandom_range(0, LETTERS - 1));
    endfunction

    // Loads often park the right rotor just short of its knock and the middle
    // one on a knock, so the middle and left rotor get carried in later encodes.
    task automatic random_item();
        int                  pick;
        logic [ACTION_W-1:0] act;
        logic [LETTER_W-1:0] lr, lm, ll;
        pick = $urandom_range(0, 99);
        if (pick < 72)
            act = ACT_ENCODE;
        else if (pick < 84)
            act = ACT_LOAD;
        else if (pick < 96)
            act = ACT_PLUG;
        else
            act = ACT_UNUSED;
        lr = any_letter();
        lm = any_letter();
        ll = any_letter();
        if ($urandom_range(0, 2) == 0)
            lr = LETTER_W'((int'(sb.knock_a[sb.right_type]) + LETTERS - 1) % LETTERS);
        if ($urandom_range(0, 2) == 0)
            lm = ($urandom_range(0, 1) == 0) ? sb.knock_a[sb.middle_type]
                                              : sb.knock_b[sb.middle_type];
        drive_item(act, any_letter(), LETTER_W'($urandom_range(0, 31)), lr, lm, ll);
    endtask

    initial
    begin
        sb                   = new();
        send_gap_pct         = 0;
        pop_stall_pct        = 0;
        quiet_cycles         = 0;
        settings_used        = 1;
        push                 = 1'b0;
        action               = ACT_ENCODE;
        letter               = '0;
        plug_value           = '0;
        load_right_position  = '0;
        load_middle_position = '0;
        load_left_position   = '0;
        cfg_valid            = 1'b0;
        cfg_index            = CFG_RIGHT_TYPE;
        cfg_data             = '0;
        rst_n                = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed part on the reset setting (III, II, I with zero rings).
        drive_item(ACT_ENCODE, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_ENCODE, 5'd25, 5'd0, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_ENCODE, 5'd31, 5'd0, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_PLUG, 5'd0, 5'd25, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_PLUG, 5'd25, 5'd0, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_PLUG, 5'd31, 5'd7, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_PLUG, 5'd3, 5'd30, 5'd0, 5'd0, 5'd0);
        // Two letters mapped onto the same one: not a permutation.
        drive_item(ACT_PLUG, 5'd1, 5'd25, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_ENCODE, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_ENCODE, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_ENCODE, 5'd3, 5'd0, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_UNUSED, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31);
        drive_item(ACT_LOAD, 5'd0, 5'd0, 5'd25, 5'd25, 5'd25);
        drive_item(ACT_ENCODE, 5'd12, 5'd0, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_LOAD, 5'd0, 5'd0, 5'd31, 5'd30, 5'd26);
        drive_item(ACT_ENCODE, 5'd12, 5'd0, 5'd0, 5'd0, 5'd0);
        // Right rotor one short of its knock, middle one short of its own.
        drive_item(ACT_LOAD, 5'd0, 5'd0, 5'd21, 5'd4, 5'd0);
        drive_item(ACT_ENCODE, 5'd7, 5'd0, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_ENCODE, 5'd7, 5'd0, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_ENCODE, 5'd7, 5'd0, 5'd0, 5'd0, 5'd0);
        // Both knocks fire on the same encode.
        drive_item(ACT_LOAD, 5'd0, 5'd0, 5'd21, 5'd5, 5'd9);
        drive_item(ACT_ENCODE, 5'd20, 5'd0, 5'd0, 5'd0, 5'd0);
        drive_item(ACT_ENCODE, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0: apply_setting(3'd7, 3'd7, 3'd7, 5'd25, 5'd25, 5'd25);
                1: apply_setting(ROTOR_I, ROTOR_I, ROTOR_I, 5'd0, 5'd0, 5'd0);
                4: apply_setting(ROTOR_IV, 3'd5, 3'd6, 5'd31, 5'd26, 5'd13);
                default: apply_setting(TYPE_W'($urandom_range(0, 7)),
                                       TYPE_W'($urandom_range(0, 7)),
                                       TYPE_W'($urandom_range(0, 7)),
                                       LETTER_W'($urandom_range(0, 31)),
                                       LETTER_W'($urandom_range(0, 31)),
                                       LETTER_W'($urandom_range(0, 31)));
            endcase
            case (ph % 4)
                0:
                begin
                    send_gap_pct  = 0;
                    pop_stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct  = 88;
                    pop_stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct  = 0;
                    pop_stall_pct = 88;
                end
                default:
                begin
                    send_gap_pct  = 36;
                    pop_stall_pct = 36;
                end
            endcase
            repeat (PHASE_ITEMS) random_item();
        end

        push          = 1'b0;
        pop_stall_pct = 0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("Ran %0d encodes, %0d rotor loads, %0d plugboard writes, %0d unused actions",
                 sb.encodes, sb.loads, sb.plug_writes, sb.others);
        $display("over %0d rotor settings; %0d results checked, %0d mismatches.",
                 settings_used, sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("rotor_cipher_machine_unit verification clean");
        else
            $display("rotor_cipher_machine_unit verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/rcm_pkg.sv
hdl/rcm_ram.sv
hdl/rcm_fifo.sv
hdl/rcm_front.sv
hdl/rcm_back.sv
hdl/rotor_cipher_machine_unit.sv
tb/rotor_cipher_machine_unit_tb.sv
